@@ sv/odt_pkg.sv @@
package odt_pkg;

    // Widths fixed by the stream fields
    localparam int FIELD_W            = 32;
    localparam int TIME_WIDTH_DEFAULT = 32;
    localparam int IN_TDATA_W         = 72;
    localparam int OUT_TDATA_W        = 104;
    localparam int CFG_INDEX_W        = 1;

    // Debounce defaults
    localparam logic [FIELD_W-1:0] DEBOUNCE_DEFAULT_MS = 32'd60000;

    // Seconds part of the debounce: debounce / 1000 = (debounce >> 3) / 125,
    // and /125 is a multiply by ceil(2^36 / 125) followed by a shift by 36.
    localparam int QUOT_W      = 23;
    localparam int PRE_SHIFT   = 3;
    localparam int RECIP_W     = 30;
    localparam int RECIP_SHIFT = 36;
    localparam int PROD_W      = (FIELD_W - PRE_SHIFT) + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_125       = 30'd549755814;
    localparam logic [QUOT_W-1:0]  LED_DEFAULT_SEC = 23'd60;

    // LED command codes
    typedef enum logic [1:0] {
        LED_NONE = 2'd0,
        LED_ON   = 2'd1,
        LED_OFF  = 2'd2
    } led_cmd_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_ALIVE = 1'b1;

    // Middle stage: state result plus the debounce seconds for the LED timeout
    typedef struct packed {
        logic                 occupied;
        led_cmd_t             led_cmd;
        logic                 report;
        logic [FIELD_W-1:0]   session;
        logic [FIELD_W-1:0]   total;
        logic [QUOT_W-1:0]    quot;
    } odt_mid_t;

    // Result item
    typedef struct packed {
        logic                 occupied;
        led_cmd_t             led_cmd;
        logic [FIELD_W-1:0]   led_timeout;
        logic                 report;
        logic [FIELD_W-1:0]   session;
        logic [FIELD_W-1:0]   total;
    } odt_out_t;

endpackage

@@ sv/occupancy_debounce_tracker.sv @@
// Occupancy tracker with debounce, one result per poll.
// A poll passes the input register, the state/quotient register and the result register
// on its way to the master side.
// Throughput: one poll per cycle unless m_tready stalls the pipeline.
// Reset (rst_n low, asynchronous): space free, start/last-event/total cleared,
// debounce 0 (60 s default), keep-alive off, all pipeline stages empty.
module occupancy_debounce_tracker #(
    parameter int TIME_WIDTH = odt_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // slave side
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // detect[0], now_ms[32:1], now_sec[64:33], zero pad [71:65]
    input  logic [odt_pkg::IN_TDATA_W-1:0]      s_tdata,
    // master side
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // occupied_now[0], led_command[2:1], led_timeout_ms[34:3], report_trigger[35],
    // session_seconds[67:36], total_seconds[99:68], zero pad [103:100]
    output logic [odt_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [odt_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [odt_pkg::FIELD_W-1:0]         cfg_data
);

    localparam int FW = odt_pkg::FIELD_W;
    localparam int TW = TIME_WIDTH;
    localparam int CW = (TW > FW) ? TW : FW;

    // Configuration registers
    logic [FW-1:0] debounce_reg;
    logic          keep_alive_reg;

    // Occupancy state
    logic          occ_reg,   occ_next;
    logic [TW-1:0] start_reg, start_next;
    logic [TW-1:0] last_reg,  last_next;
    logic [TW-1:0] total_reg, total_next;

    // Pipeline registers
    logic          in_v_reg;
    logic          in_detect_reg;
    logic [FW-1:0] in_ms_reg;
    logic [FW-1:0] in_sec_reg;
    logic          mid_v_reg;
    odt_pkg::odt_mid_t mid_reg, mid_next;
    logic          out_v_reg;
    odt_pkg::odt_out_t out_reg, out_next;

    // Stage enables
    logic en_out, en_mid, en_in;
    logic adv_in;

    // Poll datapath
    logic [TW-1:0] now_ms, now_sec;
    logic [FW-1:0] limit;
    logic [TW-1:0] since, session;
    odt_pkg::led_cmd_t led_cmd;
    logic          report;

    // LED timeout datapath
    logic [odt_pkg::PROD_W-1:0] recip_prod;
    logic [odt_pkg::QUOT_W-1:0] led_sec;
    logic [FW-1:0]              led_ms;

    // Flow control: a stage moves when the one after it is empty or moving
    assign en_out   = !out_v_reg || m_tready;
    assign en_mid   = !mid_v_reg || en_out;
    assign en_in    = !in_v_reg  || en_mid;
    assign s_tready = en_in;
    assign adv_in   = in_v_reg && en_mid;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= '0;
            keep_alive_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                odt_pkg::CFG_DEBOUNCE:   debounce_reg   <= cfg_data;
                odt_pkg::CFG_KEEP_ALIVE: keep_alive_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (en_in)
            in_v_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en_in && s_tvalid)
        begin
            in_detect_reg <= s_tdata[0];
            in_ms_reg     <= s_tdata[FW:1];
            in_sec_reg    <= s_tdata[2*FW:FW+1];
        end
    end

    // Occupancy update for one poll
    assign now_ms  = TW'(in_ms_reg);
    assign now_sec = TW'(in_sec_reg);
    assign limit   = (debounce_reg == '0) ? odt_pkg::DEBOUNCE_DEFAULT_MS : debounce_reg;

    always_comb
    begin
        occ_next   = occ_reg;
        start_next = start_reg;
        last_next  = last_reg;
        total_next = total_reg;
        led_cmd    = odt_pkg::LED_NONE;
        report     = 1'b0;
        session    = '0;
        since      = '0;

        // detection: open a session if free, and refresh the LED and last-event time
        if (in_detect_reg)
        begin
            if (!occ_reg)
            begin
                occ_next   = 1'b1;
                start_next = now_sec;
                report     = keep_alive_reg;
            end
            led_cmd   = odt_pkg::LED_ON;
            last_next = now_ms;
        end

        // debounce expiry closes the session
        if (occ_next)
        begin
            if (last_next == '0)
                last_next = now_ms;
            since = now_ms - last_next;
            if (CW'(since) > CW'(limit))
            begin
                session    = now_sec - start_next;
                total_next = total_next + session;
                occ_next   = 1'b0;
                start_next = '0;
                led_cmd    = odt_pkg::LED_OFF;
                if (keep_alive_reg)
                    report = 1'b1;
            end
        end
    end

    // Debounce seconds: reciprocal multiply, registered with the poll
    assign recip_prod = {{odt_pkg::RECIP_W{1'b0}}, debounce_reg[FW-1:odt_pkg::PRE_SHIFT]}
                      * {{(FW - odt_pkg::PRE_SHIFT){1'b0}}, odt_pkg::RECIP_125};

    always_comb
    begin
        mid_next.occupied = occ_next;
        mid_next.led_cmd  = led_cmd;
        mid_next.report   = report;
        mid_next.session  = FW'(session);
        mid_next.total    = FW'(total_next);
        mid_next.quot     = recip_prod[odt_pkg::PROD_W-1:odt_pkg::RECIP_SHIFT];
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= 1'b0;
            start_reg <= '0;
            last_reg  <= '0;
            total_reg <= '0;
        end
        else if (adv_in)
        begin
            occ_reg   <= occ_next;
            start_reg <= start_next;
            last_reg  <= last_next;
            total_reg <= total_next;
        end
    end

    // Middle register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mid_v_reg <= 1'b0;
        else if (en_mid)
            mid_v_reg <= in_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv_in)
            mid_reg <= mid_next;
    end

    // LED timeout: seconds * 1000 as shifts and subtracts (1024 - 16 - 8)
    assign led_sec = (mid_reg.quot == '0) ? odt_pkg::LED_DEFAULT_SEC : mid_reg.quot;
    assign led_ms  = (FW'(led_sec) << 10) - (FW'(led_sec) << 4) - (FW'(led_sec) << 3);

    always_comb
    begin
        out_next.occupied    = mid_reg.occupied;
        out_next.led_cmd     = mid_reg.led_cmd;
        out_next.led_timeout = (mid_reg.led_cmd == odt_pkg::LED_ON) ? led_ms : '0;
        out_next.report      = mid_reg.report;
        out_next.session     = mid_reg.session;
        out_next.total       = mid_reg.total;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en_out)
            out_v_reg <= mid_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_out && mid_v_reg)
            out_reg <= out_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {4'b0, out_reg.total, out_reg.session, out_reg.report,
                       out_reg.led_timeout, out_reg.led_cmd, out_reg.occupied};

    // Checks
    a_off_means_free: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.led_cmd == odt_pkg::LED_OFF) |-> !out_reg.occupied)
        else $error("LED off with space still occupied");

    a_on_means_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.led_cmd == odt_pkg::LED_ON)
            |-> (out_reg.occupied && out_reg.led_timeout != '0))
        else $error("LED on without occupancy or timeout");

    a_session_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.session != '0) |-> (out_reg.led_cmd == odt_pkg::LED_OFF))
        else $error("session length outside a session close");

    a_total_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (adv_in && occ_next) |-> (total_next == total_reg))
        else $error("total changed while space stays occupied");

endmodule
